[rtl/core/qrr_pkg.sv]
// qrr_pkg: shared types and constants for the quaternion rotor rotate core
// no dependencies; imported by qrr_ham_stage and quaternion_rotor_rotate_core
`default_nettype none

package qrr_pkg;

    // rotor component width, signed Q2.14
    localparam int ROT_W = 16;
    // point and result component width, signed Q8.8
    localparam int PT_W = 16;
    // fraction bits dropped when going from Q.36 back to Q8.8
    localparam int FRAC_SHIFT = 28;
    // configuration index width
    localparam int CFG_IDX_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROTOR_W = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROTOR_X = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTOR_Y = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROTOR_Z = 8'd3;

    // rotor reset value, one in Q2.14
    localparam logic signed [ROT_W-1:0] ROTOR_ONE = 16'sd16384;

    typedef struct packed {
        logic signed [ROT_W-1:0] w;
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
    } rotor_t;

endpackage

`default_nettype wire

[rtl/core/qrr_ham_stage.sv]
// qrr_ham_stage: two-stage pipelined Hamilton product of a quaternion with the rotor
// depends on qrr_pkg (rotor_t, ROT_W); CONJ selects r*a (0) or a*conj(r) (1)
`default_nettype none

module qrr_ham_stage
    import qrr_pkg::*;
#(
    parameter int IN_W = 16,
    parameter bit CONJ = 1'b0,
    parameter int SUM_W = IN_W + ROT_W + 2
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic signed [IN_W-1:0]  in_w,
    input  wire logic signed [IN_W-1:0]  in_x,
    input  wire logic signed [IN_W-1:0]  in_y,
    input  wire logic signed [IN_W-1:0]  in_z,
    input  wire rotor_t                  rotor,
    output logic                         out_valid,
    output logic signed [SUM_W-1:0]      out_w,
    output logic signed [SUM_W-1:0]      out_x,
    output logic signed [SUM_W-1:0]      out_y,
    output logic signed [SUM_W-1:0]      out_z
);

    localparam int PROD_W = IN_W + ROT_W;

    logic signed [ROT_W-1:0]  rv [4];
    logic signed [IN_W-1:0]   av [4];
    logic signed [PROD_W-1:0] prod_next [4][4];
    logic signed [PROD_W-1:0] prod_reg  [4][4];
    logic signed [SUM_W-1:0]  e [4][4];
    logic signed [SUM_W-1:0]  dot;
    logic signed [SUM_W-1:0]  sum_w_next;
    logic signed [SUM_W-1:0]  sum_x_next;
    logic signed [SUM_W-1:0]  sum_y_next;
    logic signed [SUM_W-1:0]  sum_z_next;
    logic signed [SUM_W-1:0]  sum_w_reg;
    logic signed [SUM_W-1:0]  sum_x_reg;
    logic signed [SUM_W-1:0]  sum_y_reg;
    logic signed [SUM_W-1:0]  sum_z_reg;
    logic                     prod_valid_reg;
    logic                     sum_valid_reg;

    // operand vectors: index 0 is the scalar, 1..3 are i, j, k
    always_comb
    begin
        rv[0] = rotor.w;
        rv[1] = rotor.x;
        rv[2] = rotor.y;
        rv[3] = rotor.z;
        av[0] = in_w;
        av[1] = in_x;
        av[2] = in_y;
        av[3] = in_z;
    end

    // all sixteen cross products rotor[i] * a[j]
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_next[i][j] = PROD_W'(rv[i]) * PROD_W'(av[j]);
            end
        end
    end

    // product register stage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_reg[i][j] <= prod_next[i][j];
            end
        end
    end

    // sign-extended products for the sum stage
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                e[i][j] = SUM_W'(prod_reg[i][j]);
            end
        end
    end

    // combine products; with the conjugate on the right the dot and
    // rotor-vector-times-scalar terms flip sign, the cross terms do not
    always_comb
    begin
        dot = e[1][1] + e[2][2] + e[3][3];
        if (CONJ)
        begin
            sum_w_next = e[0][0] + dot;
            sum_x_next = e[0][1] - e[1][0] + e[2][3] - e[3][2];
            sum_y_next = e[0][2] - e[2][0] + e[3][1] - e[1][3];
            sum_z_next = e[0][3] - e[3][0] + e[1][2] - e[2][1];
        end
        else
        begin
            sum_w_next = e[0][0] - dot;
            sum_x_next = e[0][1] + e[1][0] + e[2][3] - e[3][2];
            sum_y_next = e[0][2] + e[2][0] + e[3][1] - e[1][3];
            sum_z_next = e[0][3] + e[3][0] + e[1][2] - e[2][1];
        end
    end

    // sum register stage
    always_ff @(posedge clk)
    begin
        sum_w_reg <= sum_w_next;
        sum_x_reg <= sum_x_next;
        sum_y_reg <= sum_y_next;
        sum_z_reg <= sum_z_next;
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            sum_valid_reg  <= prod_valid_reg;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_w     = sum_w_reg;
    assign out_x     = sum_x_reg;
    assign out_y     = sum_y_reg;
    assign out_z     = sum_z_reg;

endmodule

`default_nettype wire

[rtl/core/quaternion_rotor_rotate_core.sv]
// quaternion_rotor_rotate_core: rotates Q8.8 point quaternions by r*p*conj(r)
// depends on qrr_pkg and qrr_ham_stage
// pipeline: start transfer to the done strobe passes two product/sum
// stages per Hamilton product, then one round and saturate stage
// throughput: one point per cycle, busy is never raised; cfg_ready is always high
// reset: rotor returns to identity (w = one, x = y = z = 0), pipeline emptied
`default_nettype none

module quaternion_rotor_rotate_core
    import qrr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic signed [PT_W-1:0]  point_w,
    input  wire logic signed [PT_W-1:0]  point_x,
    input  wire logic signed [PT_W-1:0]  point_y,
    input  wire logic signed [PT_W-1:0]  point_z,
    output logic                         done,
    output logic signed [PT_W-1:0]       rotated_w,
    output logic signed [PT_W-1:0]       rotated_x,
    output logic signed [PT_W-1:0]       rotated_y,
    output logic signed [PT_W-1:0]       rotated_z,
    output logic                         saturated,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ROT_W-1:0]        cfg_data
);

    localparam int S1_W = PT_W + ROT_W + 2;
    localparam int S2_W = S1_W + ROT_W + 2;
    localparam int RND_W = S2_W + 1;
    localparam int F_W = RND_W - FRAC_SHIFT;
    localparam logic signed [RND_W-1:0] HALF = RND_W'(1) <<< (FRAC_SHIFT - 1);
    localparam logic signed [F_W-1:0] F_MAX = F_W'(32767);
    localparam logic signed [F_W-1:0] F_MIN = -F_W'(32768);

    typedef struct packed {
        logic signed [PT_W-1:0] val;
        logic                   clip;
    } rnd_t;

    rotor_t                  rotor;
    logic signed [ROT_W-1:0] rotor_w_reg;
    logic signed [ROT_W-1:0] rotor_x_reg;
    logic signed [ROT_W-1:0] rotor_y_reg;
    logic signed [ROT_W-1:0] rotor_z_reg;
    logic                    in_valid;
    logic                    s1_valid;
    logic signed [S1_W-1:0]  s1_w;
    logic signed [S1_W-1:0]  s1_x;
    logic signed [S1_W-1:0]  s1_y;
    logic signed [S1_W-1:0]  s1_z;
    logic                    s2_valid;
    logic signed [S2_W-1:0]  s2_w;
    logic signed [S2_W-1:0]  s2_x;
    logic signed [S2_W-1:0]  s2_y;
    logic signed [S2_W-1:0]  s2_z;
    rnd_t                    rw_next;
    rnd_t                    rx_next;
    rnd_t                    ry_next;
    rnd_t                    rz_next;
    logic signed [PT_W-1:0]  rot_w_reg;
    logic signed [PT_W-1:0]  rot_x_reg;
    logic signed [PT_W-1:0]  rot_y_reg;
    logic signed [PT_W-1:0]  rot_z_reg;
    logic                    sat_reg;
    logic                    done_reg;

    // round half up from Q.36 to Q8.8 and clip to 16 bits
    function automatic rnd_t round_sat(input logic signed [S2_W-1:0] v);
        logic signed [RND_W-1:0] t;
        logic signed [F_W-1:0]   f;
        rnd_t                    r;
        t = RND_W'(v) + HALF;
        f = t[RND_W-1:FRAC_SHIFT];
        if (f > F_MAX)
        begin
            r.val  = 16'sh7FFF;
            r.clip = 1'b1;
        end
        else if (f < F_MIN)
        begin
            r.val  = 16'sh8000;
            r.clip = 1'b1;
        end
        else
        begin
            r.val  = f[PT_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    // the pipeline never stalls
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_valid  = start && !busy;

    // rotor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotor_w_reg <= ROTOR_ONE;
            rotor_x_reg <= '0;
            rotor_y_reg <= '0;
            rotor_z_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROTOR_W: rotor_w_reg <= cfg_data;
                REG_ROTOR_X: rotor_x_reg <= cfg_data;
                REG_ROTOR_Y: rotor_y_reg <= cfg_data;
                REG_ROTOR_Z: rotor_z_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        rotor.w = rotor_w_reg;
        rotor.x = rotor_x_reg;
        rotor.y = rotor_y_reg;
        rotor.z = rotor_z_reg;
    end

    // first product: r * p
    qrr_ham_stage #(
        .IN_W (PT_W),
        .CONJ (1'b0),
        .SUM_W(S1_W)
    ) u_ham_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_w     (point_w),
        .in_x     (point_x),
        .in_y     (point_y),
        .in_z     (point_z),
        .rotor    (rotor),
        .out_valid(s1_valid),
        .out_w    (s1_w),
        .out_x    (s1_x),
        .out_y    (s1_y),
        .out_z    (s1_z)
    );

    // second product: (r * p) * conj(r)
    qrr_ham_stage #(
        .IN_W (S1_W),
        .CONJ (1'b1),
        .SUM_W(S2_W)
    ) u_ham_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1_valid),
        .in_w     (s1_w),
        .in_x     (s1_x),
        .in_y     (s1_y),
        .in_z     (s1_z),
        .rotor    (rotor),
        .out_valid(s2_valid),
        .out_w    (s2_w),
        .out_x    (s2_x),
        .out_y    (s2_y),
        .out_z    (s2_z)
    );

    // round and saturate each component
    always_comb
    begin
        rw_next = round_sat(s2_w);
        rx_next = round_sat(s2_x);
        ry_next = round_sat(s2_y);
        rz_next = round_sat(s2_z);
    end

    // output registers, cleared at reset and loaded only when a result arrives
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_w_reg <= '0;
            rot_x_reg <= '0;
            rot_y_reg <= '0;
            rot_z_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else if (s2_valid)
        begin
            rot_w_reg <= rw_next.val;
            rot_x_reg <= rx_next.val;
            rot_y_reg <= ry_next.val;
            rot_z_reg <= rz_next.val;
            sat_reg   <= rw_next.clip | rx_next.clip | ry_next.clip | rz_next.clip;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_valid;
        end
    end

    assign done      = done_reg;
    assign rotated_w = rot_w_reg;
    assign rotated_x = rot_x_reg;
    assign rotated_y = rot_y_reg;
    assign rotated_z = rot_z_reg;
    assign saturated = sat_reg;

    // every result strobe traces back to an earlier start transfer
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("result strobe without matching start transfer");

    // a saturated result has at least one component on a rail
    a_sat_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |->
            (rotated_w == 16'sh7FFF || rotated_w == 16'sh8000 ||
             rotated_x == 16'sh7FFF || rotated_x == 16'sh8000 ||
             rotated_y == 16'sh7FFF || rotated_y == 16'sh8000 ||
             rotated_z == 16'sh7FFF || rotated_z == 16'sh8000))
        else $error("saturated flag set with no clipped component");

    // result ports hold between strobes
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> ($stable(rotated_w) && $stable(rotated_x) &&
                   $stable(rotated_y) && $stable(rotated_z) && $stable(saturated)))
        else $error("result ports changed without a result strobe");

endmodule

`default_nettype wire
